// ===== src/rmce_pkg.sv =====
// ----------------------------------------------------------------------------
// rmce_pkg: shared definitions of the RSA CRT exponentiation engine
// Codes of the datapath unit, operand sources, branch conditions, the
// command and status structs, and the microprogram that the controller steps.
// ----------------------------------------------------------------------------
package rmce_pkg;

   localparam int DEFAULT_WIDTH = 64;
   localparam int PCW           = 7;

   // configuration register indexes
   localparam logic [2:0] CSR_MODULUS  = 3'd0;
   localparam logic [2:0] CSR_PUB_EXP  = 3'd1;
   localparam logic [2:0] CSR_PRIV_EXP = 3'd2;
   localparam logic [2:0] CSR_PRIME_P  = 3'd3;
   localparam logic [2:0] CSR_PRIME_Q  = 3'd4;

   // datapath unit operations
   localparam logic [2:0] ALU_MOV = 3'd0;  // acc = a
   localparam logic [2:0] ALU_SHR = 3'd1;  // acc = a >> 1
   localparam logic [2:0] ALU_ADD = 3'd2;  // acc = (a + b) mod m
   localparam logic [2:0] ALU_NEG = 3'd3;  // acc = (m - a) mod m
   localparam logic [2:0] ALU_MUL = 3'd4;  // acc = (a * b) mod m, bit serial
   localparam logic [2:0] ALU_MOD = 3'd5;  // acc = a mod m, bit serial
   localparam logic [2:0] ALU_QUO = 3'd6;  // acc = a / m, bit serial

   // operand sources: scratch entries below 16; constants, keys and request from 16 up
   localparam logic [4:0] SRC_BASE = 5'd0;
   localparam logic [4:0] SRC_EXP  = 5'd1;
   localparam logic [4:0] SRC_RES  = 5'd2;
   localparam logic [4:0] SRC_D1   = 5'd3;
   localparam logic [4:0] SRC_D2   = 5'd4;
   localparam logic [4:0] SRC_A1   = 5'd5;
   localparam logic [4:0] SRC_A2   = 5'd6;
   localparam logic [4:0] SRC_QI   = 5'd7;
   localparam logic [4:0] SRC_PI   = 5'd8;
   localparam logic [4:0] SRC_IA   = 5'd9;
   localparam logic [4:0] SRC_IM   = 5'd10;
   localparam logic [4:0] SRC_N    = 5'd11;
   localparam logic [4:0] SRC_X0   = 5'd12;
   localparam logic [4:0] SRC_X1   = 5'd13;
   localparam logic [4:0] SRC_T    = 5'd14;
   localparam logic [4:0] SRC_QU   = 5'd15;
   localparam logic [4:0] SRC_K0   = 5'd16;
   localparam logic [4:0] SRC_K1   = 5'd17;
   localparam logic [4:0] SRC_NMOD = 5'd18;
   localparam logic [4:0] SRC_E    = 5'd19;
   localparam logic [4:0] SRC_D    = 5'd20;
   localparam logic [4:0] SRC_P    = 5'd21;
   localparam logic [4:0] SRC_Q    = 5'd22;
   localparam logic [4:0] SRC_V    = 5'd23;
   localparam logic [4:0] SRC_PM1  = 5'd24;
   localparam logic [4:0] SRC_QM1  = 5'd25;

   // branch conditions, tested on the unit result or the request operation
   localparam logic [3:0] C_NEXT   = 4'd0;
   localparam logic [3:0] C_ALWAYS = 4'd1;
   localparam logic [3:0] C_Z      = 4'd2;
   localparam logic [3:0] C_EVEN   = 4'd3;
   localparam logic [3:0] C_LE1    = 4'd4;
   localparam logic [3:0] C_DEC    = 4'd5;
   localparam logic [3:0] C_CALL   = 4'd6;
   localparam logic [3:0] C_RET    = 4'd7;
   localparam logic [3:0] C_DONE   = 4'd8;

   // program labels
   localparam logic [PCW-1:0] PC_ZOUT = 7'd6;
   localparam logic [PCW-1:0] PC_DEC  = 7'd7;
   localparam logic [PCW-1:0] PC_POW  = 7'd40;
   localparam logic [PCW-1:0] PC_INV  = 7'd48;

   typedef struct packed {
      logic [2:0]     alu;
      logic [4:0]     sa;
      logic [4:0]     sb;
      logic [4:0]     sm;
      logic           wr;
      logic [3:0]     dst;
      logic [3:0]     cond;
      logic [PCW-1:0] tgt;
   } instr_type;

   typedef struct packed {
      logic       accept;
      logic [4:0] rd_src;
      logic       ld_a;
      logic       ld_b;
      logic       ld_m;
      logic       go;
      logic [2:0] alu;
      logic       wr_en;
      logic [3:0] wr_dst;
      logic       out_en;
   } cmd_type;

   typedef struct packed {
      logic unit_busy;
      logic res_zero;
      logic res_le1;
      logic res_odd;
      logic dec;
   } status_type;

   function automatic instr_type mk(input logic [2:0] alu, input logic [4:0] sa,
                                    input logic [4:0] sb, input logic [4:0] sm,
                                    input logic wr, input logic [4:0] dst,
                                    input logic [3:0] cond, input logic [PCW-1:0] tgt);
      instr_type i;
      i.alu  = alu;
      i.sa   = sa;
      i.sb   = sb;
      i.sm   = sm;
      i.wr   = wr;
      i.dst  = dst[3:0];
      i.cond = cond;
      i.tgt  = tgt;
      return i;
   endfunction

   function automatic instr_type rom(input logic [PCW-1:0] pc);
      instr_type i;
      unique case (pc)
         // entry: zero modulus, then encrypt or decrypt
         7'd0:  i = mk(ALU_MOV, SRC_NMOD, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_Z, PC_ZOUT);
         7'd1:  i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_DEC, PC_DEC);
         7'd2:  i = mk(ALU_MOV, SRC_V, SRC_K0, SRC_K0, 1'b1, SRC_BASE, C_NEXT, 7'd0);
         7'd3:  i = mk(ALU_MOV, SRC_E, SRC_K0, SRC_K0, 1'b1, SRC_EXP, C_NEXT, 7'd0);
         7'd4:  i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_CALL, PC_POW);
         7'd5:  i = mk(ALU_MOV, SRC_RES, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_DONE, 7'd0);
         7'd6:  i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_DONE, 7'd0);
         // reduced private exponents
         7'd7:  i = mk(ALU_MOV, SRC_PM1, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_Z, 7'd10);
         7'd8:  i = mk(ALU_MOD, SRC_D, SRC_K0, SRC_PM1, 1'b1, SRC_D1, C_NEXT, 7'd0);
         7'd9:  i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_ALWAYS, 7'd11);
         7'd10: i = mk(ALU_MOV, SRC_D, SRC_K0, SRC_K0, 1'b1, SRC_D1, C_NEXT, 7'd0);
         7'd11: i = mk(ALU_MOV, SRC_QM1, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_Z, 7'd14);
         7'd12: i = mk(ALU_MOD, SRC_D, SRC_K0, SRC_QM1, 1'b1, SRC_D2, C_NEXT, 7'd0);
         7'd13: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_ALWAYS, 7'd15);
         7'd14: i = mk(ALU_MOV, SRC_D, SRC_K0, SRC_K0, 1'b1, SRC_D2, C_NEXT, 7'd0);
         // two powers
         7'd15: i = mk(ALU_MOV, SRC_V, SRC_K0, SRC_K0, 1'b1, SRC_BASE, C_NEXT, 7'd0);
         7'd16: i = mk(ALU_MOV, SRC_D1, SRC_K0, SRC_K0, 1'b1, SRC_EXP, C_NEXT, 7'd0);
         7'd17: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_CALL, PC_POW);
         7'd18: i = mk(ALU_MOV, SRC_RES, SRC_K0, SRC_K0, 1'b1, SRC_A1, C_NEXT, 7'd0);
         7'd19: i = mk(ALU_MOV, SRC_V, SRC_K0, SRC_K0, 1'b1, SRC_BASE, C_NEXT, 7'd0);
         7'd20: i = mk(ALU_MOV, SRC_D2, SRC_K0, SRC_K0, 1'b1, SRC_EXP, C_NEXT, 7'd0);
         7'd21: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_CALL, PC_POW);
         7'd22: i = mk(ALU_MOV, SRC_RES, SRC_K0, SRC_K0, 1'b1, SRC_A2, C_NEXT, 7'd0);
         // two inverses
         7'd23: i = mk(ALU_MOV, SRC_Q, SRC_K0, SRC_K0, 1'b1, SRC_IA, C_NEXT, 7'd0);
         7'd24: i = mk(ALU_MOV, SRC_P, SRC_K0, SRC_K0, 1'b1, SRC_IM, C_NEXT, 7'd0);
         7'd25: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_CALL, PC_INV);
         7'd26: i = mk(ALU_MOV, SRC_RES, SRC_K0, SRC_K0, 1'b1, SRC_QI, C_NEXT, 7'd0);
         7'd27: i = mk(ALU_MOV, SRC_P, SRC_K0, SRC_K0, 1'b1, SRC_IA, C_NEXT, 7'd0);
         7'd28: i = mk(ALU_MOV, SRC_Q, SRC_K0, SRC_K0, 1'b1, SRC_IM, C_NEXT, 7'd0);
         7'd29: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_CALL, PC_INV);
         7'd30: i = mk(ALU_MOV, SRC_RES, SRC_K0, SRC_K0, 1'b1, SRC_PI, C_NEXT, 7'd0);
         // recombine
         7'd31: i = mk(ALU_MOD, SRC_Q, SRC_K0, SRC_NMOD, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd32: i = mk(ALU_MUL, SRC_A1, SRC_T, SRC_NMOD, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd33: i = mk(ALU_MOD, SRC_QI, SRC_K0, SRC_NMOD, 1'b1, SRC_N, C_NEXT, 7'd0);
         7'd34: i = mk(ALU_MUL, SRC_T, SRC_N, SRC_NMOD, 1'b1, SRC_D1, C_NEXT, 7'd0);
         7'd35: i = mk(ALU_MOD, SRC_P, SRC_K0, SRC_NMOD, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd36: i = mk(ALU_MUL, SRC_A2, SRC_T, SRC_NMOD, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd37: i = mk(ALU_MOD, SRC_PI, SRC_K0, SRC_NMOD, 1'b1, SRC_N, C_NEXT, 7'd0);
         7'd38: i = mk(ALU_MUL, SRC_T, SRC_N, SRC_NMOD, 1'b1, SRC_D2, C_NEXT, 7'd0);
         7'd39: i = mk(ALU_ADD, SRC_D1, SRC_D2, SRC_NMOD, 1'b0, SRC_K0, C_DONE, 7'd0);
         // power: RES = BASE^EXP mod N
         7'd40: i = mk(ALU_MOD, SRC_BASE, SRC_K0, SRC_NMOD, 1'b1, SRC_BASE, C_NEXT, 7'd0);
         7'd41: i = mk(ALU_MOV, SRC_K1, SRC_K0, SRC_K0, 1'b1, SRC_RES, C_NEXT, 7'd0);
         7'd42: i = mk(ALU_MOV, SRC_EXP, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_Z, 7'd47);
         7'd43: i = mk(ALU_MOV, SRC_EXP, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_EVEN, 7'd45);
         7'd44: i = mk(ALU_MUL, SRC_RES, SRC_BASE, SRC_NMOD, 1'b1, SRC_RES, C_NEXT, 7'd0);
         7'd45: i = mk(ALU_MUL, SRC_BASE, SRC_BASE, SRC_NMOD, 1'b1, SRC_BASE, C_NEXT, 7'd0);
         7'd46: i = mk(ALU_SHR, SRC_EXP, SRC_K0, SRC_K0, 1'b1, SRC_EXP, C_ALWAYS, 7'd42);
         7'd47: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_RET, 7'd0);
         // inverse: RES = IA^-1 mod IM by extended Euclid
         7'd48: i = mk(ALU_MOV, SRC_IM, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_LE1, 7'd65);
         7'd49: i = mk(ALU_MOV, SRC_IM, SRC_K0, SRC_K0, 1'b1, SRC_N, C_NEXT, 7'd0);
         7'd50: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b1, SRC_X0, C_NEXT, 7'd0);
         7'd51: i = mk(ALU_MOV, SRC_K1, SRC_K0, SRC_K0, 1'b1, SRC_X1, C_NEXT, 7'd0);
         7'd52: i = mk(ALU_MOV, SRC_IA, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_LE1, 7'd64);
         7'd53: i = mk(ALU_MOV, SRC_N, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_Z, 7'd65);
         7'd54: i = mk(ALU_QUO, SRC_IA, SRC_K0, SRC_N, 1'b1, SRC_QU, C_NEXT, 7'd0);
         7'd55: i = mk(ALU_MOD, SRC_IA, SRC_K0, SRC_N, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd56: i = mk(ALU_MOV, SRC_N, SRC_K0, SRC_K0, 1'b1, SRC_IA, C_NEXT, 7'd0);
         7'd57: i = mk(ALU_MOV, SRC_T, SRC_K0, SRC_K0, 1'b1, SRC_N, C_NEXT, 7'd0);
         7'd58: i = mk(ALU_MOD, SRC_QU, SRC_K0, SRC_IM, 1'b1, SRC_QU, C_NEXT, 7'd0);
         7'd59: i = mk(ALU_MUL, SRC_QU, SRC_X0, SRC_IM, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd60: i = mk(ALU_NEG, SRC_T, SRC_K0, SRC_IM, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd61: i = mk(ALU_ADD, SRC_X1, SRC_T, SRC_IM, 1'b1, SRC_T, C_NEXT, 7'd0);
         7'd62: i = mk(ALU_MOV, SRC_X0, SRC_K0, SRC_K0, 1'b1, SRC_X1, C_NEXT, 7'd0);
         7'd63: i = mk(ALU_MOV, SRC_T, SRC_K0, SRC_K0, 1'b1, SRC_X0, C_ALWAYS, 7'd52);
         7'd64: i = mk(ALU_MOV, SRC_X1, SRC_K0, SRC_K0, 1'b1, SRC_RES, C_RET, 7'd0);
         7'd65: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b1, SRC_RES, C_RET, 7'd0);
         default: i = mk(ALU_MOV, SRC_K0, SRC_K0, SRC_K0, 1'b0, SRC_K0, C_DONE, 7'd0);
      endcase
      return i;
   endfunction

endpackage

// ===== src/rmce_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmce_ctrl: microprogram sequencer
// Steps the program, reads three operands, runs the datapath unit, writes
// back and branches on the unit result or the request operation.
// ----------------------------------------------------------------------------
module rmce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  rmce_pkg::status_type status,
   output rmce_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RA   = 3'd1;
   localparam logic [2:0] S_RB   = 3'd2;
   localparam logic [2:0] S_RM   = 3'd3;
   localparam logic [2:0] S_LM   = 3'd4;
   localparam logic [2:0] S_GO   = 3'd5;
   localparam logic [2:0] S_RUN  = 3'd6;
   localparam logic [2:0] S_WB   = 3'd7;

   logic [2:0]                st_ff, st_in;
   logic [rmce_pkg::PCW-1:0] pc_ff, pc_in;
   logic [rmce_pkg::PCW-1:0] ret_ff, ret_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rmce_pkg::instr_type       ins;
   logic                      taken;

   assign ins = rmce_pkg::rom(pc_ff);

   always_comb begin
      case (ins.cond)
         rmce_pkg::C_ALWAYS: taken = 1'b1;
         rmce_pkg::C_Z:      taken = status.res_zero;
         rmce_pkg::C_EVEN:   taken = !status.res_odd;
         rmce_pkg::C_LE1:    taken = status.res_le1;
         rmce_pkg::C_DEC:    taken = status.dec;
         default:            taken = 1'b0;
      endcase
   end

   always_comb begin
      st_in        = st_ff;
      pc_in        = pc_ff;
      ret_in       = ret_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.alu      = ins.alu;
      cmd.wr_dst   = ins.dst;
      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               pc_in      = '0;
               st_in      = S_RA;
            end
         end
         S_RA: begin
            cmd.rd_src = ins.sa;
            st_in      = S_RB;
         end
         S_RB: begin
            cmd.rd_src = ins.sb;
            cmd.ld_a   = 1'b1;
            st_in      = S_RM;
         end
         S_RM: begin
            cmd.rd_src = ins.sm;
            cmd.ld_b   = 1'b1;
            st_in      = S_LM;
         end
         S_LM: begin
            cmd.ld_m = 1'b1;
            st_in    = S_GO;
         end
         S_GO: begin
            cmd.go = 1'b1;
            st_in  = S_RUN;
         end
         S_RUN: begin
            if (!status.unit_busy) begin
               st_in = S_WB;
            end
         end
         S_WB: begin
            cmd.wr_en = ins.wr;
            st_in     = S_RA;
            case (ins.cond)
               rmce_pkg::C_CALL: begin
                  ret_in = pc_ff + 1'b1;
                  pc_in  = ins.tgt;
               end
               rmce_pkg::C_RET: pc_in = ret_ff;
               rmce_pkg::C_DONE: begin
                  cmd.out_en   = 1'b1;
                  rsp_valid_in = 1'b1;
                  st_in        = S_IDLE;
               end
               default: pc_in = taken ? ins.tgt : pc_ff + 1'b1;
            endcase
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         pc_ff        <= '0;
         ret_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pc_ff        <= pc_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/rmce_dpath.sv =====
// ----------------------------------------------------------------------------
// rmce_dpath: key registers, scratch memory and the bit-serial unit
// The unit does modular multiply by double-and-add and division by
// restoring shift-subtract, one operand bit per cycle.
// ----------------------------------------------------------------------------
module rmce_dpath #(
   parameter int WIDTH = rmce_pkg::DEFAULT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data,
   input  logic                 req_op,
   input  logic [63:0]          req_value,
   input  rmce_pkg::cmd_type    cmd,
   output rmce_pkg::status_type status,
   output logic [63:0]          rsp_result
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] mod_ff, pexp_ff, dexp_ff;
   logic [31:0]      p_ff, q_ff;
   logic             op_ff;
   logic [WIDTH-1:0] v_ff;

   logic [WIDTH-1:0] mem [16];
   logic [WIDTH-1:0] mem_q_ff;
   logic [WIDTH-1:0] spec_ff, spec_in;
   logic             sel_ff;
   logic [WIDTH-1:0] operand;

   logic [WIDTH-1:0] opa_ff, opb_ff, opm_ff;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic [2:0]       alu_ff, alu_in;
   logic [63:0]      rsp_result_ff;

   logic [63:0]      p64, q64;
   logic [WIDTH-1:0] p_w, q_w;
   logic [WIDTH:0]   m_x, add_s, dbl, mac, rem;

   // hold key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff  <= WIDTH'(6);
         pexp_ff <= WIDTH'(1);
         dexp_ff <= WIDTH'(1);
         p_ff    <= 32'd2;
         q_ff    <= 32'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            rmce_pkg::CSR_MODULUS:  mod_ff  <= csr_data[WIDTH-1:0];
            rmce_pkg::CSR_PUB_EXP:  pexp_ff <= csr_data[WIDTH-1:0];
            rmce_pkg::CSR_PRIV_EXP: dexp_ff <= csr_data[WIDTH-1:0];
            rmce_pkg::CSR_PRIME_P:  p_ff    <= csr_data[31:0];
            rmce_pkg::CSR_PRIME_Q:  q_ff    <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_op;
         v_ff  <= req_value[WIDTH-1:0];
      end
   end

   assign p64 = 64'(p_ff);
   assign q64 = 64'(q_ff);
   assign p_w = p64[WIDTH-1:0];
   assign q_w = q64[WIDTH-1:0];

   always_comb begin
      case (cmd.rd_src)
         rmce_pkg::SRC_K1:   spec_in = WIDTH'(1);
         rmce_pkg::SRC_NMOD: spec_in = mod_ff;
         rmce_pkg::SRC_E:    spec_in = pexp_ff;
         rmce_pkg::SRC_D:    spec_in = dexp_ff;
         rmce_pkg::SRC_P:    spec_in = p_w;
         rmce_pkg::SRC_Q:    spec_in = q_w;
         rmce_pkg::SRC_V:    spec_in = v_ff;
         rmce_pkg::SRC_PM1:  spec_in = (p_w == '0) ? '0 : p_w - 1'b1;
         rmce_pkg::SRC_QM1:  spec_in = (q_w == '0) ? '0 : q_w - 1'b1;
         default:            spec_in = '0;
      endcase
   end

   // scratch memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_dst] <= acc_ff;
      end
      mem_q_ff <= mem[cmd.rd_src[3:0]];
      spec_ff  <= spec_in;
      sel_ff   <= cmd.rd_src[4];
   end

   assign operand = sel_ff ? spec_ff : mem_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.ld_a) opa_ff <= operand;
      if (cmd.ld_b) opb_ff <= operand;
      if (cmd.ld_m) opm_ff <= operand;
   end

   assign m_x = {1'b0, opm_ff};

   always_comb begin
      add_s  = {1'b0, opa_ff} + {1'b0, opb_ff};
      if (add_s >= m_x) add_s = add_s - m_x;
      dbl = {acc_ff, 1'b0};
      if (dbl >= m_x) dbl = dbl - m_x;
      mac = {1'b0, dbl[WIDTH-1:0]} + {1'b0, opa_ff};
      if (mac >= m_x) mac = mac - m_x;
      if (!sh_ff[WIDTH-1]) mac = dbl;
      rem = {acc_ff, sh_ff[WIDTH-1]};
      if (rem >= m_x) rem = rem - m_x;
   end

   always_comb begin
      acc_in = acc_ff;
      sh_in  = sh_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      alu_in = alu_ff;
      if (cmd.go) begin
         alu_in = cmd.alu;
         cnt_in = CW'(WIDTH - 1);
         quo_in = '0;
         case (cmd.alu)
            rmce_pkg::ALU_MOV: acc_in = opa_ff;
            rmce_pkg::ALU_SHR: acc_in = opa_ff >> 1;
            rmce_pkg::ALU_ADD: acc_in = add_s[WIDTH-1:0];
            rmce_pkg::ALU_NEG: acc_in = (opa_ff == '0) ? '0 : opm_ff - opa_ff;
            rmce_pkg::ALU_MUL: begin
               acc_in = '0;
               sh_in  = opb_ff;
               run_in = 1'b1;
            end
            default: begin
               acc_in = '0;
               sh_in  = opa_ff;
               run_in = 1'b1;
            end
         endcase
      end else if (run_ff) begin
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) run_in = 1'b0;
         if (alu_ff == rmce_pkg::ALU_MUL) begin
            acc_in = mac[WIDTH-1:0];
         end else begin
            acc_in = rem[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], ({acc_ff, sh_ff[WIDTH-1]} >= m_x)};
            // finish a quotient request with the quotient in place of the remainder
            if (cnt_ff == '0 && alu_ff == rmce_pkg::ALU_QUO) acc_in = quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      alu_ff <= alu_in;
      if (cmd.out_en) rsp_result_ff <= 64'(acc_ff);
   end

   assign status.unit_busy = run_ff;
   assign status.res_zero  = (acc_ff == '0);
   assign status.res_le1   = (acc_ff[WIDTH-1:1] == '0);
   assign status.res_odd   = acc_ff[0];
   assign status.dec       = op_ff;
   assign rsp_result       = rsp_result_ff;

endmodule

// ===== src/rsa_modexp_crt_engine.sv =====
// ----------------------------------------------------------------------------
// rsa_modexp_crt_engine: RSA encrypt and CRT decrypt with a stored key
// A microprogrammed controller drives one bit-serial multiply/divide unit.
//
//   channel   ports                                   handshake
//   request   start, busy, req_op, req_value          start & !busy
//   result    rsp_valid, rsp_result                   one-cycle strobe
//   csr       csr_valid, csr_ready, csr_index, csr_data   valid & ready
//
// Each micro-instruction steps through the states read a, read b, read m,
// load m, go, run and write back; a modular multiply or a division stays
// in run on the shared bit-serial unit, one operand bit per cycle. Encrypt
// runs one power; decrypt runs two such powers, two Euclid loops and the
// reductions of the exponents and of the recombination. Synchronous reset
// restores the key registers; the scratch memory is not cleared. rsp_valid
// is high for a single cycle and rsp_result holds until the next result;
// the receiver cannot stall.
// ----------------------------------------------------------------------------
module rsa_modexp_crt_engine #(
   parameter int WIDTH = rmce_pkg::DEFAULT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   output logic [63:0] rsp_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   rmce_pkg::cmd_type    cmd;
   rmce_pkg::status_type status;

   assign csr_ready = 1'b1;

   rmce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   rmce_dpath #(.WIDTH(WIDTH)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_op     (req_op),
      .req_value  (req_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_result (rsp_result)
   );

endmodule

// ===== src/rmce_checker.sv =====
// ----------------------------------------------------------------------------
// rmce_checker: port-level checks of the RSA CRT engine
// Watches the request, result and csr ports over time.
// ----------------------------------------------------------------------------
module rmce_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but engine not busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("request ended without a result");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind rsa_modexp_crt_engine rmce_checker u_rmce_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
